FILE: hdl/chi_pkg.sv
// Package for the chained hash index: field widths, operation and status codes.
// Depends on nothing; used by the interfaces and every module of the block.
package chi_pkg;
  localparam int unsigned NumBuckets  = 1024;
  localparam int unsigned PoolEntries = 4096;
  localparam int unsigned OpW     = 2;
  localparam int unsigned BucketW = 10;
  localparam int unsigned DataW   = 32;
  localparam int unsigned SlotW   = 13;
  localparam int unsigned StatW   = 2;

  typedef enum logic [OpW-1:0] {
    OP_LOOKUP = 2'd0, OP_INSERT = 2'd1, OP_REM_TAG = 2'd2, OP_REM_PAGE = 2'd3
  } op_e;

  localparam logic [StatW-1:0] ST_OK = 2'd0;
  localparam logic [StatW-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [StatW-1:0] ST_FULL = 2'd2;
endpackage

FILE: hdl/chi_req_if.sv
// Request and result channel interfaces for the chained hash index.
// Depends on chi_pkg.
interface chi_req_if;
  logic                        valid;
  logic                        ready;
  logic [chi_pkg::OpW-1:0]     op;
  logic [chi_pkg::BucketW-1:0] bucket_index;
  logic [chi_pkg::DataW-1:0]   key_tag;
  logic [chi_pkg::DataW-1:0]   page_offset;
  modport source (output valid, op, bucket_index, key_tag, page_offset, input ready);
  modport sink (input valid, op, bucket_index, key_tag, page_offset, output ready);
endinterface

interface chi_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [chi_pkg::StatW-1:0] status;
  logic [chi_pkg::DataW-1:0] found_page;
  logic [chi_pkg::SlotW-1:0] slot_used;
  modport source (output valid, status, found_page, slot_used, input ready);
  modport sink (input valid, status, found_page, slot_used, output ready);
endinterface

FILE: hdl/chained_hash_index_top.sv
// Chained hash index: head table, slot pool memories and the chain-walk sequencer.
// Depends on chi_pkg and the channel interfaces in chi_req_if.sv.
//
// Usage: requests arrive on req (op, bucket, tag, page); one result per request
// leaves on rsp (status, found page, slot). Requests are processed one at a time.
// After reset a clearing pass writes null into every head-table entry (S_CLEAR),
// during which req.ready stays low.
// Each visited slot needs one synchronous read of the slot memory (S_READ) and a
// compare (S_CMP). A request passes S_HEAD and S_HEADW and then walks its chain;
// a miss then goes through S_ALLOC, an append also through S_ALLOCW and S_LINK,
// a removal through S_LINK, and every request ends in S_OUT.
// The result is built in a staging register and then moves to the output
// register; the next request is taken while a result still waits, but a second
// result stalls the sequencer until rsp.ready.
// Reset empties the pool and the free list.
module chained_hash_index_top #(
  parameter int unsigned NUM_BUCKETS  = chi_pkg::NumBuckets,
  parameter int unsigned POOL_ENTRIES = chi_pkg::PoolEntries
) (
  input  logic clk_i,
  input  logic rst_ni,
  chi_req_if.sink   req,
  chi_rsp_if.source rsp
);
  import chi_pkg::*;
  localparam int unsigned BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned SW = $clog2(POOL_ENTRIES + 1);
  localparam int unsigned AW = $clog2(POOL_ENTRIES);
  localparam logic [SW-1:0] NullSlot = SW'(POOL_ENTRIES);
  localparam logic [SW-1:0] PoolMax = SW'(POOL_ENTRIES);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HEAD, S_HEADW, S_READ, S_CMP, S_ALLOC, S_ALLOCW, S_LINK, S_OUT
  } state_e;

  // Memories.
  logic [SW-1:0]    head_mem [NUM_BUCKETS];
  logic [DataW-1:0] tag_mem  [POOL_ENTRIES];
  logic [DataW-1:0] page_mem [POOL_ENTRIES];
  logic [SW-1:0]    link_mem [POOL_ENTRIES];
  logic             valid_mem[POOL_ENTRIES];

  state_e            state_q;
  logic [BW-1:0]     clr_q, bkt_q;
  logic [OpW-1:0]    op_q;
  logic [DataW-1:0]  tag_q, page_q;
  logic [SW-1:0]     cur_q, prev_q, steps_q, free_q, hw_q, new_q;
  logic              from_free_q;
  logic [SW-1:0]     head_rd_q, link_rd_q;
  logic [DataW-1:0]  tag_rd_q, page_rd_q;
  logic              vld_rd_q;
  logic [StatW-1:0]  res_stat_q;
  logic [DataW-1:0]  res_page_q;
  logic [SlotW-1:0]  res_slot_q;
  logic              ovalid_q;
  logic [StatW-1:0]  ostat_q;
  logic [DataW-1:0]  opage_q;
  logic [SlotW-1:0]  oslot_q;

  // Read ports, registered.
  logic [AW-1:0] rd_addr;
  assign rd_addr = AW'(cur_q);
  always_ff @(posedge clk_i) begin
    head_rd_q <= head_mem[bkt_q];
    tag_rd_q  <= tag_mem[rd_addr];
    page_rd_q <= page_mem[rd_addr];
    link_rd_q <= link_mem[rd_addr];
    vld_rd_q  <= valid_mem[rd_addr];
  end

  logic hit;
  assign hit = vld_rd_q && (tag_rd_q == tag_q) &&
               ((op_q != OP_REM_PAGE) || (page_rd_q == page_q));

  logic [BW-1:0] bkt_in;
  assign bkt_in = BW'(req.bucket_index % NUM_BUCKETS);

  assign req.ready = (state_q == S_IDLE);
  assign rsp.valid = ovalid_q;
  assign rsp.status = ostat_q;
  assign rsp.found_page = opage_q;
  assign rsp.slot_used = oslot_q;

  // Chain-walk sequencer: writes a head entry or link; prev null means the head.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; clr_q <= '0; ovalid_q <= 1'b0;
      free_q <= '0; hw_q <= '0;
    end else begin
      if (state_q == S_OUT && (!ovalid_q || rsp.ready)) ovalid_q <= 1'b1;
      else if (rsp.ready) ovalid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          head_mem[clr_q] <= NullSlot;
          clr_q <= clr_q + 1'b1;
          if (clr_q == BW'(NUM_BUCKETS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: if (req.valid) begin
          op_q <= req.op; bkt_q <= bkt_in; tag_q <= req.key_tag;
          page_q <= req.page_offset; state_q <= S_HEAD;
        end
        S_HEAD: state_q <= S_HEADW;
        S_HEADW: begin
          cur_q <= head_rd_q; prev_q <= NullSlot; steps_q <= '0;
          from_free_q <= 1'b0;
          state_q <= S_READ;
        end
        S_READ: begin
          if (cur_q >= PoolMax || steps_q >= PoolMax) state_q <= S_ALLOC;
          else state_q <= S_CMP;
        end
        S_CMP: begin
          if (hit) begin
            if (op_q == OP_INSERT) page_mem[rd_addr] <= page_q;
            if (op_q == OP_REM_TAG || op_q == OP_REM_PAGE) begin
              valid_mem[rd_addr] <= 1'b0;
              link_mem[rd_addr] <= free_q;
              free_q <= cur_q;
              new_q <= link_rd_q;
              state_q <= S_LINK;
            end else state_q <= S_OUT;
            res_stat_q <= ST_OK;
            res_page_q <= (op_q == OP_LOOKUP) ? page_rd_q : '0;
            res_slot_q <= SlotW'(cur_q);
          end else begin
            prev_q <= cur_q; cur_q <= link_rd_q; steps_q <= steps_q + 1'b1;
            state_q <= S_READ;
          end
        end
        S_ALLOC: begin
          res_stat_q <= ST_NOT_FOUND; res_page_q <= '0; res_slot_q <= SlotW'(NullSlot);
          state_q <= S_OUT;
          if (op_q == OP_INSERT) begin
            if (free_q == hw_q) begin
              if (hw_q >= PoolMax) res_stat_q <= ST_FULL;
              else begin
                new_q <= hw_q; hw_q <= hw_q + 1'b1; free_q <= hw_q + 1'b1;
                state_q <= S_ALLOCW;
              end
            end else if (free_q >= PoolMax) res_stat_q <= ST_FULL;
            else begin
              // Read the free slot's link to advance the free list.
              new_q <= free_q; cur_q <= free_q; from_free_q <= 1'b1;
              state_q <= S_ALLOCW;
            end
          end
        end
        S_ALLOCW: begin
          // The old link of a slot taken from the free list is read this cycle.
          tag_mem[AW'(new_q)] <= tag_q;
          page_mem[AW'(new_q)] <= page_q;
          valid_mem[AW'(new_q)] <= 1'b1;
          link_mem[AW'(new_q)] <= NullSlot;
          res_stat_q <= ST_OK; res_slot_q <= SlotW'(new_q);
          state_q <= S_LINK;
        end
        S_LINK: begin
          if (from_free_q) free_q <= link_rd_q;
          if (prev_q < PoolMax) link_mem[AW'(prev_q)] <= new_q;
          else head_mem[bkt_q] <= new_q;
          state_q <= S_OUT;
        end
        S_OUT: if (!ovalid_q || rsp.ready) begin
          ostat_q <= res_stat_q; opage_q <= res_page_q; oslot_q <= res_slot_q;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: hdl/chi_checker.sv
// Port-level checker for the chained hash index, bound to the top level.
// Depends on chi_pkg.
module chi_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic [chi_pkg::StatW-1:0] status,
  input logic [chi_pkg::DataW-1:0] found_page
);
  import chi_pkg::*;
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> (status == ST_OK || status == ST_NOT_FOUND || status == ST_FULL))
    else $error("bad status");
  a_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid && status != ST_OK) |-> found_page == '0)
    else $error("page on miss");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid && req_ready) |=> !req_ready)
    else $error("two requests at once");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid && !rsp_ready) |=> rsp_valid)
    else $error("result dropped");
endmodule

bind chained_hash_index_top chi_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .status(rsp.status),
  .found_page(rsp.found_page)
);

FILE: tb/chained_hash_index_top_test.sv
// Self-checking test for the chained hash index: drives request beats, predicts each
// result with a behavioural copy of the chains and free list, and checks result beats.
// Depends on chi_pkg, chi_req_if.sv and the block under test.
module chained_hash_index_top_test;
  import chi_pkg::*;

  localparam int unsigned NullSlot = PoolEntries;

  typedef struct packed {
    op_e                op;
    logic [BucketW-1:0] bucket;
    logic [DataW-1:0]   tag;
    logic [DataW-1:0]   page;
  } request_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [DataW-1:0] page;
    logic [SlotW-1:0] slot;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  chi_req_if req ();
  chi_rsp_if rsp ();

  chained_hash_index_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req.sink),
    .rsp    (rsp.source)
  );

  always #1 clk_i = ~clk_i;

  // Behavioural copy of the index.
  int unsigned heads [NumBuckets];
  logic [DataW-1:0] tags [PoolEntries];
  logic [DataW-1:0] pages [PoolEntries];
  int unsigned links [PoolEntries];
  bit valids [PoolEntries];
  int unsigned free_head;
  int unsigned high_water;

  request_t pending_reqs [$];
  answer_t  expected_answers [$];
  int       error_count = 0;
  bit       stimulus_done = 1'b0;
  int       hold_off = 0;      // long receiver stall, counted down in its own process
  int       send_gap = 0;
  int       recv_gap = 0;

  // Tags used by the random part, kept few so that chains form and hit.
  logic [DataW-1:0] tag_pool [8];

  function automatic answer_t predict_index(request_t r);
    answer_t a;
    int unsigned b, cur, prev, hit, steps, s;
    bit got;
    a.status = ST_NOT_FOUND;
    a.page = '0;
    a.slot = SlotW'(NullSlot);
    b = r.bucket % NumBuckets;
    cur = heads[b];
    prev = NullSlot;
    hit = NullSlot;
    steps = 0;
    while (cur < PoolEntries && steps < PoolEntries) begin
      if (valids[cur] && tags[cur] == r.tag && (r.op != OP_REM_PAGE || pages[cur] == r.page))
      begin
        hit = cur;
        break;
      end
      prev = cur;
      cur = links[cur];
      steps++;
    end
    case (r.op)
      OP_LOOKUP: begin
        if (hit != NullSlot) begin
          a.status = ST_OK;
          a.page = pages[hit];
          a.slot = SlotW'(hit);
        end
      end
      OP_INSERT: begin
        if (hit != NullSlot) begin
          pages[hit] = r.page;
          a.status = ST_OK;
          a.slot = SlotW'(hit);
        end else begin
          got = 1'b0;
          if (free_head == high_water) begin
            if (high_water < PoolEntries) begin
              s = high_water;
              high_water++;
              free_head = high_water;
              got = 1'b1;
            end
          end else if (free_head < PoolEntries) begin
            s = free_head;
            free_head = links[s];
            got = 1'b1;
          end
          if (got) begin
            links[s] = NullSlot;
            tags[s] = r.tag;
            pages[s] = r.page;
            valids[s] = 1'b1;
            if (prev < PoolEntries) links[prev] = s;
            else heads[b] = s;
            a.status = ST_OK;
            a.slot = SlotW'(s);
          end else begin
            a.status = ST_FULL;
          end
        end
      end
      default: begin
        if (hit != NullSlot) begin
          cur = links[hit];
          valids[hit] = 1'b0;
          links[hit] = free_head;
          free_head = hit;
          if (prev < PoolEntries) links[prev] = cur;
          else heads[b] = cur;
          a.status = ST_OK;
          a.slot = SlotW'(hit);
        end
      end
    endcase
    return a;
  endfunction

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic request_t make_req(op_e op, int unsigned bucket,
                                        logic [DataW-1:0] tag, logic [DataW-1:0] page);
    request_t r;
    r.op = op;
    r.bucket = BucketW'(bucket);
    r.tag = tag;
    r.page = page;
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: a beat leaves the queue when accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req.valid <= 1'b0;
      req.op <= '0;
      req.bucket_index <= '0;
      req.key_tag <= '0;
      req.page_offset <= '0;
    end else begin
      if (req.valid && req.ready) begin
        expected_answers.push_back(predict_index(pending_reqs.pop_front()));
        send_gap = pick_gap();
      end
      if ((!req.valid || req.ready) || !req.valid) begin
        if (send_gap > 0) begin
          send_gap--;
          req.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req.valid <= 1'b1;
          req.op <= pending_reqs[0].op;
          req.bucket_index <= pending_reqs[0].bucket;
          req.key_tag <= pending_reqs[0].tag;
          req.page_offset <= pending_reqs[0].page;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("unexpected result beat", '0, '0);
        end else begin
          want = expected_answers.pop_front();
          if (rsp.status !== want.status) report_mismatch("status", rsp.status, want.status);
          if (rsp.found_page !== want.page)
            report_mismatch("found_page", rsp.found_page, want.page);
          if (rsp.slot_used !== want.slot)
            report_mismatch("slot_used", rsp.slot_used, want.slot);
        end
      end
      if (hold_off > 0) begin
        rsp.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
        if (rsp.valid && rsp.ready) recv_gap = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_off > 0) hold_off <= hold_off - 1;
  end

  initial begin
    request_t r;
    int unsigned k, bucket, roll;
    foreach (heads[i]) heads[i] = NullSlot;
    foreach (valids[i]) begin
      valids[i] = 1'b0;
      links[i] = 0;
      tags[i] = '0;
      pages[i] = '0;
    end
    free_head = 0;
    high_water = 0;
    foreach (tag_pool[i]) tag_pool[i] = $urandom();
    tag_pool[0] = '0;
    tag_pool[1] = '1;

    // Directed: empty buckets, extremes, overwrite, both removals, misses.
    pending_reqs.push_back(make_req(OP_LOOKUP, 0, '0, '0));
    pending_reqs.push_back(make_req(OP_REM_TAG, 1023, '1, '0));
    pending_reqs.push_back(make_req(OP_REM_PAGE, 5, '1, '1));
    pending_reqs.push_back(make_req(OP_INSERT, 0, '0, '1));
    pending_reqs.push_back(make_req(OP_INSERT, 1023, '1, '0));
    pending_reqs.push_back(make_req(OP_INSERT, 0, 32'h5555_5555, 32'hAAAA_AAAA));
    pending_reqs.push_back(make_req(OP_INSERT, 0, 32'hAAAA_AAAA, 32'h5555_5555));
    pending_reqs.push_back(make_req(OP_LOOKUP, 0, 32'hAAAA_AAAA, '0));
    pending_reqs.push_back(make_req(OP_INSERT, 0, '0, 32'h1234_5678));
    pending_reqs.push_back(make_req(OP_LOOKUP, 0, '0, '0));
    pending_reqs.push_back(make_req(OP_LOOKUP, 1023, '1, '0));
    pending_reqs.push_back(make_req(OP_LOOKUP, 0, 32'h0BAD_F00D, '0));
    pending_reqs.push_back(make_req(OP_REM_PAGE, 0, 32'h5555_5555, 32'h0));
    pending_reqs.push_back(make_req(OP_REM_PAGE, 0, 32'h5555_5555, 32'hAAAA_AAAA));
    pending_reqs.push_back(make_req(OP_REM_TAG, 0, '0, '0));
    pending_reqs.push_back(make_req(OP_REM_TAG, 0, '0, '0));
    pending_reqs.push_back(make_req(OP_INSERT, 0, 32'h7777_0000, 32'h1));
    pending_reqs.push_back(make_req(OP_LOOKUP, 0, 32'hAAAA_AAAA, '0));
    pending_reqs.push_back(make_req(OP_REM_TAG, 1023, '1, '0));
    pending_reqs.push_back(make_req(OP_LOOKUP, 1023, '1, '0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Random: a few buckets and few tags so that chains grow, hit and shrink.
    for (k = 0; k < 500; k++) begin
      roll = $urandom_range(0, 99);
      bucket = (roll < 85) ? $urandom_range(0, 7) : $urandom_range(0, 1023);
      r.op = op_e'($urandom_range(0, 3));
      if ($urandom_range(0, 2) != 0) r.op = ($urandom_range(0, 1) != 0) ? OP_INSERT : r.op;
      r.bucket = BucketW'(bucket);
      r.tag = ($urandom_range(0, 9) < 8) ? tag_pool[$urandom_range(0, 7)] : $urandom();
      r.page = ($urandom_range(0, 3) == 0) ? 32'(($urandom_range(0, 3))) : $urandom();
      pending_reqs.push_back(r);
      if (k == 250) begin
        wait (pending_reqs.size() < 200);
      end
    end

    // Long receiver stall while the sender keeps offering beats.
    @(posedge clk_i);
    while (expected_answers.size() == 0) @(posedge clk_i);
    hold_off <= 300;

    wait (pending_reqs.size() == 0);
    while (expected_answers.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
